@@ hw/rtl/exif_orientation_extractor_macros.svh @@
// Assertion macros shared by the RTL of the Exif orientation extractor.
`ifndef EXIF_ORIENTATION_EXTRACTOR_MACROS_SVH
`define EXIF_ORIENTATION_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define EOE_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("exif_orientation_extractor: same-cycle check failed");

`define EOE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("exif_orientation_extractor: next-cycle check failed");

`else

`define EOE_ASSERT_SAME(name, ante, cons)

`define EOE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ hw/rtl/exif_pkg.sv @@
package exif_pkg;

    localparam int POS_W = 17;

    localparam logic [7:0] APP1_CODE = 8'hE1;
    localparam logic [7:0] II_BYTE = 8'h49;
    localparam logic [7:0] MM_BYTE = 8'h4D;
    localparam logic [7:0] TIFF_MAGIC = 8'h2A;
    localparam logic [15:0] ORIENT_TAG = 16'h0112;
    localparam logic [15:0] SHORT_TYPE = 16'd3;
    localparam logic [3:0] ENTRY_LAST = 4'd11;
    localparam logic [POS_W-1:0] MIN_SEG_LEN = 17'd32;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
    localparam logic [POS_W-1:0] IDENT_LEN = 17'd6;
    localparam logic [15:0] ORIENT_MAX = 16'd8;

    function automatic logic [7:0] exif_ident_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0: val = 8'h45;
            3'd1: val = 8'h78;
            3'd2: val = 8'h69;
            3'd3: val = 8'h66;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] rd16(input logic big_endian, input logic [7:0] a,
                                         input logic [7:0] b);
        return big_endian ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] rd32(input logic big_endian, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic [7:0] d);
        return big_endian ? {a, b, c, d} : {d, c, b, a};
    endfunction

endpackage

@@ hw/rtl/exif_orientation_extractor.sv @@
// Exif orientation extractor.
// Input channel s_*: one payload byte of a JPEG marker segment per word, the
// marker code of the segment in s_tuser and s_tlast on the final byte.
// Output channel m_*: exactly one word per segment, sent for its last byte,
// carrying found and the orientation value (0 when not found or above 8).
// Throughput: one byte per cycle while s_tready is high; every byte is
// handled by one pass of parser logic between the parser registers and the
// two-entry output stage, where the result word is registered.
// When the receiver stalls, a second result parks in a skid register and
// s_tready stays high until that register fills; s_tready then drops until
// the receiver takes a word.
// Reset (aresetn low, synchronous) empties the output stage and returns the
// parser to the start of a segment; the parser also returns there after
// every last byte. No clearing pass is needed after reset.
`include "exif_orientation_extractor_macros.svh"

module exif_orientation_extractor #(
    parameter int SEARCH_WINDOW = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [7:0] s_tuser,   // [7:0] marker_code
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] found, [4:1] orientation, [7:5] zero
);

    localparam int TW = $clog2(SEARCH_WINDOW);
    localparam logic [exif_pkg::POS_W-1:0] SEARCH_END = 17'(SEARCH_WINDOW + 2);

    typedef enum logic [1:0] {
        ST_PENDING,
        ST_FAIL,
        ST_HIT
    } status_t;

    logic [exif_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [TW-1:0]   tpos_reg, tpos_next;
    logic            be_reg, be_next;
    logic            ifd_armed_reg, ifd_armed_next;
    logic            cnt_loaded_reg, cnt_loaded_next;
    logic [31:0]     ifd_start_reg, ifd_start_next;
    logic [15:0]     tag_total_reg, tag_total_next;
    logic [15:0]     tags_scanned_reg, tags_scanned_next;
    logic [3:0]      entry_idx_reg, entry_idx_next;
    status_t         status_reg, status_next;
    logic [3:0]      held_reg, held_next;
    logic [7:0]      win_reg [11];
    logic [7:0]      win_next [11];
    logic [32:0]     ifd_end_reg;

    logic            m_valid_reg, m_valid_next;
    logic            out_found_reg, out_found_next;
    logic [3:0]      out_orient_reg, out_orient_next;
    logic            skid_valid_reg, skid_valid_next;
    logic            skid_found_reg, skid_found_next;
    logic [3:0]      skid_orient_reg, skid_orient_next;

    logic            accept;
    logic            push;
    logic            pop;
    logic            res_found;
    logic [3:0]      res_orient;

    logic [exif_pkg::POS_W-1:0] offset_end;
    logic [31:0]     offset_val;
    logic [32:0]     ifd_sum;
    logic [15:0]     replay_pair;
    logic [15:0]     live_count;
    logic [15:0]     ent_tag;
    logic [15:0]     ent_type;
    logic [31:0]     ent_count;
    logic [15:0]     ent_value;
    logic [17:0]     seg_len;
    logic            ii_hit;
    logic            mm_hit;

    assign accept = s_tvalid && s_tready;
    assign push = accept && s_tlast;
    assign pop = m_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'b000, out_orient_reg, out_found_reg};

    assign offset_end = exif_pkg::POS_W'(tpos_reg) + 17'd7;
    assign offset_val = exif_pkg::rd32(be_reg, win_reg[2], win_reg[1], win_reg[0], s_tdata);
    assign ifd_sum = 33'(tpos_reg) + {1'b0, offset_val};
    assign live_count = exif_pkg::rd16(be_reg, win_reg[0], s_tdata);
    assign ent_tag = exif_pkg::rd16(be_reg, win_reg[10], win_reg[9]);
    assign ent_type = exif_pkg::rd16(be_reg, win_reg[8], win_reg[7]);
    assign ent_count = exif_pkg::rd32(be_reg, win_reg[6], win_reg[5], win_reg[4], win_reg[3]);
    assign ent_value = exif_pkg::rd16(be_reg, win_reg[2], win_reg[1]);
    assign seg_len = {1'b0, pos_reg} + 18'd1;

    assign ii_hit = win_reg[2] == exif_pkg::II_BYTE && win_reg[1] == exif_pkg::II_BYTE
                 && win_reg[0] == exif_pkg::TIFF_MAGIC && s_tdata == 8'h00;
    assign mm_hit = win_reg[2] == exif_pkg::MM_BYTE && win_reg[1] == exif_pkg::MM_BYTE
                 && win_reg[0] == 8'h00 && s_tdata == exif_pkg::TIFF_MAGIC;

    always_comb begin
        unique case (offset_val[2:0])
            3'd0: replay_pair = exif_pkg::rd16(be_reg, win_reg[6], win_reg[5]);
            3'd1: replay_pair = exif_pkg::rd16(be_reg, win_reg[5], win_reg[4]);
            3'd2: replay_pair = exif_pkg::rd16(be_reg, win_reg[4], win_reg[3]);
            3'd3: replay_pair = exif_pkg::rd16(be_reg, win_reg[3], win_reg[2]);
            3'd4: replay_pair = exif_pkg::rd16(be_reg, win_reg[2], win_reg[1]);
            3'd5: replay_pair = exif_pkg::rd16(be_reg, win_reg[1], win_reg[0]);
            default: replay_pair = exif_pkg::rd16(be_reg, win_reg[0], s_tdata);
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        tpos_next = tpos_reg;
        be_next = be_reg;
        ifd_armed_next = ifd_armed_reg;
        cnt_loaded_next = cnt_loaded_reg;
        ifd_start_next = ifd_start_reg;
        tag_total_next = tag_total_reg;
        tags_scanned_next = tags_scanned_reg;
        entry_idx_next = entry_idx_reg;
        status_next = status_reg;
        held_next = held_reg;
        win_next = win_reg;
        res_found = 1'b0;
        res_orient = 4'd0;

        if (accept) begin
            win_next[0] = s_tdata;
            for (int i = 1; i < 11; i++) begin
                win_next[i] = win_reg[i-1];
            end

            if (pos_reg >= exif_pkg::POS_MAX) begin
                status_next = ST_FAIL;
            end else begin
                pos_next = pos_reg + 17'd1;
                if (s_tuser != exif_pkg::APP1_CODE) begin
                    status_next = ST_FAIL;
                end else if (status_reg == ST_PENDING) begin
                    if (pos_reg < exif_pkg::IDENT_LEN
                        && s_tdata != exif_pkg::exif_ident_byte(pos_reg[2:0])) begin
                        status_next = ST_FAIL;
                    end else if (tpos_reg == '0) begin
                        if (pos_reg >= 17'd4) begin
                            if (ii_hit) begin
                                be_next = 1'b0;
                                tpos_next = TW'(pos_reg - 17'd3);
                            end else if (mm_hit) begin
                                be_next = 1'b1;
                                tpos_next = TW'(pos_reg - 17'd3);
                            end else if (pos_reg >= SEARCH_END) begin
                                status_next = ST_FAIL;
                            end
                        end
                    end else if (!ifd_armed_reg) begin
                        if (pos_reg == offset_end) begin
                            if (ifd_sum[32]) begin
                                status_next = ST_FAIL;
                            end else begin
                                ifd_start_next = ifd_sum[31:0];
                                ifd_armed_next = 1'b1;
                                if (offset_val < 32'd7) begin
                                    cnt_loaded_next = 1'b1;
                                    tag_total_next = replay_pair;
                                    tags_scanned_next = '0;
                                    entry_idx_next = 4'd6 - {1'b0, offset_val[2:0]};
                                    if (replay_pair == '0) begin
                                        status_next = ST_FAIL;
                                    end
                                end
                            end
                        end
                    end else if (!cnt_loaded_reg) begin
                        if (33'(pos_reg) == {1'b0, ifd_start_reg} + 33'd1) begin
                            cnt_loaded_next = 1'b1;
                            tag_total_next = live_count;
                            tags_scanned_next = '0;
                            entry_idx_next = '0;
                            if (live_count == '0) begin
                                status_next = ST_FAIL;
                            end
                        end
                    end else if (entry_idx_reg == exif_pkg::ENTRY_LAST) begin
                        entry_idx_next = '0;
                        if (ent_tag == exif_pkg::ORIENT_TAG) begin
                            if (ent_type == exif_pkg::SHORT_TYPE && ent_count == 32'd1) begin
                                held_next = (ent_value <= exif_pkg::ORIENT_MAX)
                                          ? ent_value[3:0] : 4'd0;
                                status_next = ST_HIT;
                            end else begin
                                status_next = ST_FAIL;
                            end
                        end else begin
                            tags_scanned_next = tags_scanned_reg + 16'd1;
                            if ({1'b0, tags_scanned_reg} + 17'd1 >= {1'b0, tag_total_reg}) begin
                                status_next = ST_FAIL;
                            end
                        end
                    end else begin
                        entry_idx_next = entry_idx_reg + 4'd1;
                    end
                end
            end

            if (s_tlast) begin
                res_found = status_next == ST_HIT && pos_reg >= exif_pkg::MIN_SEG_LEN - 17'd1
                         && ifd_end_reg <= 33'(seg_len);
                res_orient = res_found ? held_next : 4'd0;
                pos_next = '0;
                tpos_next = '0;
                be_next = 1'b0;
                ifd_armed_next = 1'b0;
                cnt_loaded_next = 1'b0;
                ifd_start_next = '0;
                tag_total_next = '0;
                tags_scanned_next = '0;
                entry_idx_next = '0;
                status_next = ST_PENDING;
                held_next = '0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_found_next = out_found_reg;
        out_orient_next = out_orient_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_orient_next = skid_orient_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_found_next = skid_found_reg;
                out_orient_next = skid_orient_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_found_next = res_found;
                out_orient_next = res_orient;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg) begin
                m_valid_next = 1'b1;
                out_found_next = res_found;
                out_orient_next = res_orient;
            end else begin
                skid_valid_next = 1'b1;
                skid_found_next = res_found;
                skid_orient_next = res_orient;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        ifd_start_reg <= ifd_start_next;
        held_reg <= held_next;
        out_found_reg <= out_found_next;
        out_orient_reg <= out_orient_next;
        skid_found_reg <= skid_found_next;
        skid_orient_reg <= skid_orient_next;
        ifd_end_reg <= {1'b0, ifd_start_reg} + 33'd2 + 33'({tag_total_reg, 3'b000})
                     + 33'({tag_total_reg, 2'b00});
        if (!aresetn) begin
            pos_reg <= '0;
            tpos_reg <= '0;
            be_reg <= 1'b0;
            ifd_armed_reg <= 1'b0;
            cnt_loaded_reg <= 1'b0;
            tag_total_reg <= '0;
            tags_scanned_reg <= '0;
            entry_idx_reg <= '0;
            status_reg <= ST_PENDING;
            m_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            tpos_reg <= tpos_next;
            be_reg <= be_next;
            ifd_armed_reg <= ifd_armed_next;
            cnt_loaded_reg <= cnt_loaded_next;
            tag_total_reg <= tag_total_next;
            tags_scanned_reg <= tags_scanned_next;
            entry_idx_reg <= entry_idx_next;
            status_reg <= status_next;
            m_valid_reg <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    `EOE_ASSERT_SAME(a_skid_behind_main, skid_valid_reg, m_valid_reg)
    `EOE_ASSERT_NEXT(a_push_gives_word, push, m_valid_reg)
    `EOE_ASSERT_SAME(a_hit_needs_count, status_reg == ST_HIT, cnt_loaded_reg)
    `EOE_ASSERT_SAME(a_count_needs_ifd, cnt_loaded_reg, ifd_armed_reg && tpos_reg != '0)

endmodule
